// File: hdl/bsd_pkg.sv
`default_nettype none
package bsd_pkg;

	// storage geometry
	localparam int DEPTH = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// operation codes
	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_POP = 3'd1,
		OP_PEEK = 3'd2,
		OP_DUMP_DOWN = 3'd3,
		OP_DUMP_UP = 3'd4
	} op_t;

	// command and result words
	typedef struct packed {
		logic [2:0] operation;
		logic signed [WORD_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] word;
		logic last;
	} result_t;

	// microprogram addresses
	typedef enum logic [2:0] {
		UPC_IDLE = 3'd0,
		UPC_PUSH = 3'd1,
		UPC_POP = 3'd2,
		UPC_PEEK = 3'd3,
		UPC_DOWN = 3'd4,
		UPC_UP = 3'd5,
		UPC_READ = 3'd6
	} upc_t;

	// datapath actions
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_POP,
		ACT_SET_PEEK,
		ACT_SET_DOWN,
		ACT_SET_UP,
		ACT_READ
	} act_t;

	// sequencing kinds
	typedef enum logic [1:0] {
		SEQ_DISPATCH,
		SEQ_JUMP,
		SEQ_IF_EMPTY,
		SEQ_LOOP
	} seq_t;

	typedef struct packed {
		logic busy;
		act_t act;
		seq_t seq;
		upc_t target;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic empty;
		logic final_word;
	} status_t;

endpackage
`default_nettype wire

// File: hdl/bounded_stack_with_dump_core.sv
`default_nettype none
// Bounded LIFO stack of signed 32-bit words with peek and two dump orders.
// A command word is taken when start is high and busy is low. Results come
// out one per cycle on result with result_valid high for that single cycle;
// the receiver cannot stall them, so it must take every word as it comes.
// Steps per accepted command: push and pop run their own step and return to
// idle; peek and dumps run a set-up step, then a read step with one RAM read
// per word, and no reads when the stack is empty. An unknown code leaves busy
// low, so the next command can be taken in the next cycle. The last result
// word appears in the cycle after its read, i.e. in the cycle the next command
// can be taken. The steps follow from the microcode sequence and the single
// read port of the entry RAM. Capacity writes are always ready and should be
// made while busy is low and no result is pending.
module bounded_stack_with_dump_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire bsd_pkg::cmd_t cmd,
	output logic busy,
	output logic result_valid,
	output bsd_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [bsd_pkg::CAP_W-1:0] cfg_data
);
	import bsd_pkg::*;

	ctl_t ctl;
	status_t status;
	logic accept;
	logic [WORD_W-1:0] value_q;
	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] eff_cap;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0] ptr_q;
	logic down_q;
	logic pend_q;
	logic pend_last_q;
	logic push_ok;
	logic [WORD_W-1:0] rd_data;

	// microcoded control
	bsd_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(cmd.operation),
		.status(status),
		.ctl(ctl)
	);

	assign busy = ctl.busy;
	assign accept = start && !ctl.busy;
	assign cfg_ready = 1'b1;

	// capacity saturates at the storage depth
	assign eff_cap = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
	assign push_ok = CAP_W'(fill_q) < eff_cap;

	assign status.empty = (fill_q == '0);
	assign status.final_word = (cnt_q == CNT_W'(1));

	// entry storage
	bsd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we((ctl.act == ACT_PUSH) && push_ok),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(value_q),
		.re(ctl.act == ACT_READ),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	// result word follows the registered read
	assign result_valid = pend_q;
	assign result.word = rd_data;
	assign result.last = pend_last_q;

	// push value latch
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= cmd.push_value;
		end
	end

	// datapath registers driven by the control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			fill_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			down_q <= 1'b0;
			pend_q <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			pend_q <= (ctl.act == ACT_READ);
			pend_last_q <= (ctl.act == ACT_READ) && status.final_word;
			case (ctl.act)
				ACT_PUSH: begin
					if (push_ok) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				ACT_POP: begin
					if (!status.empty) begin
						fill_q <= fill_q - CNT_W'(1);
					end
				end
				ACT_SET_PEEK: begin
					cnt_q <= CNT_W'(1);
					ptr_q <= ADDR_W'(fill_q - CNT_W'(1));
					down_q <= 1'b1;
				end
				ACT_SET_DOWN: begin
					cnt_q <= fill_q;
					ptr_q <= ADDR_W'(fill_q - CNT_W'(1));
					down_q <= 1'b1;
				end
				ACT_SET_UP: begin
					cnt_q <= fill_q;
					ptr_q <= '0;
					down_q <= 1'b0;
				end
				ACT_READ: begin
					cnt_q <= cnt_q - CNT_W'(1);
					ptr_q <= down_q ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/bsd_ram.sv
`default_nettype none
module bsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/bsd_seq.sv
`default_nettype none
module bsd_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] operation,
	input wire bsd_pkg::status_t status,
	output bsd_pkg::ctl_t ctl
);
	import bsd_pkg::*;

	upc_t upc_q;
	upc_t upc_d;

	// control store, one word per step
	function automatic ctl_t ucode(upc_t pc);
		ctl_t c;
		case (pc)
			UPC_IDLE: c = '{busy: 1'b0, act: ACT_NONE, seq: SEQ_DISPATCH, target: UPC_IDLE};
			UPC_PUSH: c = '{busy: 1'b1, act: ACT_PUSH, seq: SEQ_JUMP, target: UPC_IDLE};
			UPC_POP: c = '{busy: 1'b1, act: ACT_POP, seq: SEQ_JUMP, target: UPC_IDLE};
			UPC_PEEK: c = '{busy: 1'b1, act: ACT_SET_PEEK, seq: SEQ_IF_EMPTY, target: UPC_READ};
			UPC_DOWN: c = '{busy: 1'b1, act: ACT_SET_DOWN, seq: SEQ_IF_EMPTY, target: UPC_READ};
			UPC_UP: c = '{busy: 1'b1, act: ACT_SET_UP, seq: SEQ_IF_EMPTY, target: UPC_READ};
			UPC_READ: c = '{busy: 1'b1, act: ACT_READ, seq: SEQ_LOOP, target: UPC_IDLE};
			default: c = '{busy: 1'b1, act: ACT_NONE, seq: SEQ_JUMP, target: UPC_IDLE};
		endcase
		return c;
	endfunction

	// entry point of each operation's routine
	function automatic upc_t dispatch(logic [2:0] op);
		upc_t pc;
		case (op)
			OP_PUSH: pc = UPC_PUSH;
			OP_POP: pc = UPC_POP;
			OP_PEEK: pc = UPC_PEEK;
			OP_DUMP_DOWN: pc = UPC_DOWN;
			OP_DUMP_UP: pc = UPC_UP;
			default: pc = UPC_IDLE;
		endcase
		return pc;
	endfunction

	assign ctl = ucode(upc_q);

	// next step selection
	always_comb begin
		case (ctl.seq)
			SEQ_DISPATCH: upc_d = start ? dispatch(operation) : upc_q;
			SEQ_JUMP: upc_d = ctl.target;
			SEQ_IF_EMPTY: upc_d = status.empty ? UPC_IDLE : ctl.target;
			SEQ_LOOP: upc_d = status.final_word ? ctl.target : upc_q;
			default: upc_d = UPC_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule
`default_nettype wire

// File: sim/tb_bounded_stack_with_dump_core.sv
`default_nettype none
module tb_bounded_stack_with_dump_core;
	import bsd_pkg::*;

	// undefined operation codes, ignored by the block
	localparam logic [2:0] OP_UNDEF_LO = 3'd5;
	localparam logic [2:0] OP_UNDEF_MID = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_ALL_ONES = 32'hffff_ffff;
	localparam logic [CAP_W-1:0] CAP_TOP = 7'd127;

	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 600;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		logic [2:0] op;
		logic [31:0] value;
		logic typed;
		logic silent;
		logic [31:0] word;
		logic last;
	} stim_row_t;

	localparam int NUM_ROWS = 23;
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		'{OP_PEEK, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_POP, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_DUMP_DOWN, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_DUMP_UP, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_PUSH, WORD_MIN, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_PEEK, 32'd0, 1'b1, 1'b0, WORD_MIN, 1'b1},
		'{OP_PUSH, WORD_MAX, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_PEEK, WORD_ALL_ONES, 1'b1, 1'b0, WORD_MAX, 1'b1},
		'{OP_PUSH, WORD_ALL_ONES, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_PEEK, 32'd0, 1'b1, 1'b0, WORD_ALL_ONES, 1'b1},
		'{OP_PUSH, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_DUMP_DOWN, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_DUMP_UP, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_UNDEF_LO, WORD_ALL_ONES, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_UNDEF_MID, 32'h1234_5678, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_UNDEF_HI, WORD_MIN, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_POP, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_PEEK, 32'd0, 1'b1, 1'b0, WORD_ALL_ONES, 1'b1},
		'{OP_POP, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_POP, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_POP, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{OP_POP, WORD_ALL_ONES, 1'b1, 1'b1, 32'd0, 1'b0},
		'{OP_DUMP_UP, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic result_valid;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// per-command expectation override, travels with cmd
	logic row_typed = 1'b0;
	logic row_silent = 1'b0;
	result_t row_result = '0;

	// stack model
	logic [WORD_W-1:0] model_mem [DEPTH];
	int model_fill = 0;
	int model_cap = int'(CAP_RESET);
	int peak_fill = 0;

	result_t pending_words [$];
	int fail_count = 0;
	int cmd_count = 0;
	int word_count = 0;
	int cfg_count = 0;
	bit gap_mode = 1'b1;
	int stall_cycles = 0;

	bounded_stack_with_dump_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// apply one command to the model, queue the words it should produce
	task automatic predict_stack_cmd(input cmd_t c, output result_t words [$]);
		int lim;
		int n;
		words = {};
		lim = (model_cap > DEPTH) ? DEPTH : model_cap;
		n = model_fill;
		case (c.operation)
			OP_PUSH: begin
				if (n < lim) begin
					model_mem[n] = c.push_value;
					model_fill = n + 1;
					if (model_fill > peak_fill)
						peak_fill = model_fill;
				end
			end
			OP_POP: begin
				if (n > 0)
					model_fill = n - 1;
			end
			OP_PEEK: begin
				if (n > 0)
					words.push_back('{word: model_mem[n-1], last: 1'b1});
			end
			OP_DUMP_DOWN: begin
				for (int i = n; i > 0; i--)
					words.push_back('{word: model_mem[i-1], last: (i == 1)});
			end
			OP_DUMP_UP: begin
				for (int i = 0; i < n; i++)
					words.push_back('{word: model_mem[i], last: (i + 1 == n)});
			end
			default: ;
		endcase
	endtask

	// monitor: check outgoing words, predict accepted commands, track capacity
	always @(posedge clk) begin
		result_t fresh [$];
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				word_count++;
				if (pending_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word %h last %b", $time, result.word,
						result.last);
				end else begin
					want = pending_words.pop_front();
					if (result.word !== want.word) begin
						fail_count++;
						$display("%0t: word mismatch expected %h actual %h", $time,
							want.word, result.word);
					end
					if (result.last !== want.last) begin
						fail_count++;
						$display("%0t: last mismatch expected %b actual %b", $time,
							want.last, result.last);
					end
				end
			end
			if (start && !busy) begin
				cmd_count++;
				predict_stack_cmd(cmd, fresh);
				if (row_typed) begin
					if (!row_silent)
						pending_words.push_back(row_result);
				end else begin
					foreach (fresh[i])
						pending_words.push_back(fresh[i]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				cfg_count++;
				model_cap = int'(cfg_data);
			end
		end
	end

	// watchdog on cycles where nothing moves
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_bounded_stack_with_dump_core failed");
		$finish;
	end

	// drop start for a while, with noise on the command bus
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		row_typed <= 1'b0;
		cmd <= '{operation: 3'($urandom()), push_value: $urandom()};
		repeat (cycles) @(posedge clk);
	endtask

	task automatic issue_cmd(input logic [2:0] op, input logic [31:0] value,
		input logic typed, input logic silent, input result_t typed_res);
		if (gap_mode && $urandom_range(0, 4) == 0)
			hold_off($urandom_range(1, 19));
		start <= 1'b1;
		cmd <= '{operation: op, push_value: value};
		row_typed <= typed;
		row_silent <= silent;
		row_result <= typed_res;
		do @(posedge clk); while (busy);
	endtask

	// wait until the block is idle and no word is outstanding
	task automatic settle();
		start <= 1'b0;
		row_typed <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_ALL_ONES;
			3: return 32'd0;
			default: return $urandom();
		endcase
	endfunction

	// push share in percent, the rest split among the other operations
	function automatic logic [2:0] random_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return OP_PUSH;
		r = (r - push_pct) * 100 / (100 - push_pct);
		if (r < 40)
			return OP_POP;
		if (r < 64)
			return OP_PEEK;
		if (r < 79)
			return OP_DUMP_DOWN;
		if (r < 94)
			return OP_DUMP_UP;
		return 3'($urandom_range(int'(OP_UNDEF_LO), int'(OP_UNDEF_HI)));
	endfunction

	task automatic run_random(input int count, input int push_pct);
		repeat (count)
			issue_cmd(random_op(push_pct), random_word(), 1'b0, 1'b0, '0);
	endtask

	initial begin
		stim_row_t row;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset capacity
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			issue_cmd(row.op, row.value, row.typed, row.silent,
				'{word: row.word, last: row.last});
		end

		// zero capacity, every push ignored
		set_capacity('0);
		run_random(5, 50);

		// tiny stack, full most of the time
		set_capacity(7'd3);
		run_random(8, 55);

		// capacity above depth saturates; fill to the top and overflow once,
		// back to back with no gaps from here on
		set_capacity(CAP_TOP);
		gap_mode = 1'b0;
		for (int i = 0; i <= DEPTH; i++)
			issue_cmd(OP_PUSH, random_word(), 1'b0, 1'b0, '0);
		issue_cmd(OP_PEEK, '0, 1'b0, 1'b0, '0);
		issue_cmd(OP_DUMP_DOWN, '0, 1'b0, 1'b0, '0);
		issue_cmd(OP_DUMP_UP, '0, 1'b0, 1'b0, '0);

		// capacity lowered below the fill level, stored words stay visible
		set_capacity(7'd2);
		issue_cmd(OP_PUSH, random_word(), 1'b0, 1'b0, '0);
		issue_cmd(OP_DUMP_UP, '0, 1'b0, 1'b0, '0);
		run_random(4, 20);

		settle();
		$display("covered %0d commands and %0d words, %0d capacity writes from 0 to 127",
			cmd_count, word_count, cfg_count);
		$display("stack reached %0d entries, overflow, underflow and undefined codes hit",
			peak_fill);
		if (fail_count == 0)
			$display("tb_bounded_stack_with_dump_core passed");
		else
			$display("tb_bounded_stack_with_dump_core failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hdl/bsd_pkg.sv
hdl/bsd_ram.sv
hdl/bsd_seq.sv
hdl/bounded_stack_with_dump_core.sv
sim/tb_bounded_stack_with_dump_core.sv
